/* hw/rtl/nms2d_pkg.sv */
// ----------------------------------------------------------------------------
// nms2d_pkg
// Shared types, constants and helpers for the 2-D non-maximum suppression core.
// ----------------------------------------------------------------------------
package nms2d_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int MaxRadius = 6;

  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int StoreRows = 2 * MaxRadius + 1;
  localparam int SlotW     = $clog2(StoreRows);
  localparam int AddrW     = SlotW + ColW;
  localparam int MemDepth  = StoreRows * MaxWidth;

  localparam int WidthW    = 11;
  localparam int HeightW   = 13;
  localparam int RadW      = 3;
  localparam int PixW      = 16;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgRadius = 2'd2,
    CfgThresh = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        is_peak;
    logic        last_of_run;
  } dec_out_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic centre_rd;
    logic scan_init;
    logic scan_rd;
    logic advance;
  } nms2d_cmd_t;

  typedef struct packed {
    logic has_run;
    logic scan_last;
    logic run_last;
  } nms2d_sts_t;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(StoreRows - 1)) r = '0;
    else r = s + SlotW'(1);
    return r;
  endfunction

  function automatic logic [SlotW-1:0] slot_sub(input logic [SlotW-1:0] s,
                                               input logic [RadW-1:0]  d);
    logic [SlotW:0] t;
    t = {1'b0, s} + (SlotW+1)'(StoreRows) - {{(SlotW+1-RadW){1'b0}}, d};
    if (t >= (SlotW+1)'(StoreRows)) t = t - (SlotW+1)'(StoreRows);
    return t[SlotW-1:0];
  endfunction

endpackage

/* hw/rtl/nms2d_ctrl.sv */
// ----------------------------------------------------------------------------
// nms2d_ctrl
// Sequencer: takes an item, stores it, then scans the window of each decided
// pixel and hands out one decision at a time.
// ----------------------------------------------------------------------------
module nms2d_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nms2d_pkg::nms2d_cmd_t cmd_o,
  input  nms2d_pkg::nms2d_sts_t sts_i
);
  import nms2d_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StPrep   = 7'b0000010,
    StCentre = 7'b0000100,
    StCwait  = 7'b0001000,
    StScan   = 7'b0010000,
    StDrain  = 7'b0100000,
    StEmit   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.has_run ? StCentre : StIdle;
      end
      StCentre: begin
        cmd_o.centre_rd = 1'b1;
        state_d         = StCwait;
      end
      StCwait: begin
        cmd_o.scan_init = 1'b1;
        state_d         = StScan;
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = StDrain;
      end
      StDrain: begin
        state_d = StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.run_last ? StIdle : StCentre;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/nms2d_dp.sv */
// ----------------------------------------------------------------------------
// nms2d_dp
// Datapath: configuration, position counters, line store, window scan and
// the decision registers.
// ----------------------------------------------------------------------------
module nms2d_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nms2d_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [nms2d_pkg::CfgW-1:0]          cfg_data_i,
  input  nms2d_pkg::pix_in_t                  in_item_i,
  output nms2d_pkg::dec_out_t                 out_item_o,
  input  nms2d_pkg::nms2d_cmd_t               cmd_i,
  output nms2d_pkg::nms2d_sts_t               sts_o
);
  import nms2d_pkg::*;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [RadW-1:0]    rad_q;
  logic [PixW-1:0]    thresh_q;

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [RadW-1:0]    rad_eff;
  logic [WidthW-1:0]  wm1;
  logic [HeightW-1:0] hm1;

  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [SlotW-1:0] slot_q;

  logic [PixW-1:0] pix_q;
  logic            fs_q;

  logic [PixW-1:0] mem [MemDepth];
  logic [PixW-1:0] rdata_q;

  logic [RowW-1:0]  pr_q, rhi_q;
  logic [ColW-1:0]  pc_q, clo_q, chi_q;
  logic [SlotW-1:0] prslot_q;

  logic [RowW-1:0]  wr_q, wrhi_q;
  logic [ColW-1:0]  wc_q, wclo_q, wchi_q;
  logic [SlotW-1:0] wslot_q;

  logic [PixW-1:0] centre_q;
  logic            peak_q;
  logic            pend_q;
  logic            self_q;
  logic            early_q;

  // prep logic
  logic [ColW-1:0]    c0, c1;
  logic [RowW-1:0]    r0;
  logic [HeightW-1:0] r1, r2, rn;
  logic [SlotW-1:0]   s0, s1, s2;
  logic [RowW-1:0]    rc, rlo, rhi;
  logic [ColW-1:0]    cc, clo, chi;
  logic               rows_ok, cols_ok;
  logic [WidthW-1:0]  cn;
  logic [RowW-1:0]    row_n;
  logic [ColW-1:0]    col_n;
  logic [SlotW-1:0]   slot_n;
  logic [SlotW-1:0]   rlo_slot;

  // window bounds
  logic [RowW-1:0]    wrlo;
  logic [HeightW-1:0] wr_sum;
  logic [RowW-1:0]    wrhi;
  logic [WidthW-1:0]  wc_sum;
  logic [ColW-1:0]    wclo, wchi;

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic               violate;

  always_comb begin
    if (width_q == '0) w_eff = WidthW'(1);
    else if (width_q > WidthW'(MaxWidth)) w_eff = WidthW'(MaxWidth);
    else w_eff = width_q;
    if (height_q == '0) h_eff = HeightW'(1);
    else if (height_q > HeightW'(MaxHeight)) h_eff = HeightW'(MaxHeight);
    else h_eff = height_q;
    if (rad_q > RadW'(MaxRadius)) rad_eff = RadW'(MaxRadius);
    else rad_eff = rad_q;
    wm1 = w_eff - WidthW'(1);
    hm1 = h_eff - HeightW'(1);
  end

  always_comb begin
    c0 = fs_q ? '0 : col_q;
    r0 = fs_q ? '0 : row_q;
    s0 = fs_q ? '0 : slot_q;
    if ({1'b0, c0} >= w_eff) begin
      c1 = '0;
      r1 = {1'b0, r0} + HeightW'(1);
      s1 = slot_inc(s0);
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
      s1 = s0;
    end
    if (r1 >= h_eff) begin
      r2 = '0;
      s2 = '0;
    end else begin
      r2 = r1;
      s2 = s1;
    end
    rc = r2[RowW-1:0];
    cc = c1;

    rows_ok = 1'b1;
    if ({1'b0, rc} == hm1) begin
      rhi = rc;
      rlo = (rc >= RowW'(rad_eff)) ? rc - RowW'(rad_eff) : '0;
    end else if (rc >= RowW'(rad_eff)) begin
      rlo = rc - RowW'(rad_eff);
      rhi = rlo;
    end else begin
      rlo     = '0;
      rhi     = '0;
      rows_ok = 1'b0;
    end
    cols_ok = 1'b1;
    if ({1'b0, cc} == wm1) begin
      chi = cc;
      clo = (cc >= ColW'(rad_eff)) ? cc - ColW'(rad_eff) : '0;
    end else if (cc >= ColW'(rad_eff)) begin
      clo = cc - ColW'(rad_eff);
      chi = clo;
    end else begin
      clo     = '0;
      chi     = '0;
      cols_ok = 1'b0;
    end
    rlo_slot = slot_sub(s2, RadW'(rc - rlo));

    cn = {1'b0, cc} + WidthW'(1);
    rn = {1'b0, rc} + HeightW'(1);
    if (cn >= w_eff) begin
      col_n = '0;
      if (rn >= h_eff) begin
        row_n  = '0;
        slot_n = '0;
      end else begin
        row_n  = rn[RowW-1:0];
        slot_n = slot_inc(s2);
      end
    end else begin
      col_n  = cn[ColW-1:0];
      row_n  = rc;
      slot_n = s2;
    end
  end

  always_comb begin
    wrlo   = (pr_q >= RowW'(rad_eff)) ? pr_q - RowW'(rad_eff) : '0;
    wr_sum = {1'b0, pr_q} + HeightW'(rad_eff);
    wrhi   = (wr_sum < h_eff) ? wr_sum[RowW-1:0] : hm1[RowW-1:0];
    wclo   = (pc_q >= ColW'(rad_eff)) ? pc_q - ColW'(rad_eff) : '0;
    wc_sum = {1'b0, pc_q} + WidthW'(rad_eff);
    wchi   = (wc_sum < w_eff) ? wc_sum[ColW-1:0] : wm1[ColW-1:0];
  end

  assign mem_we    = cmd_i.prep;
  assign mem_waddr = {s2, cc};
  assign mem_re    = cmd_i.centre_rd | cmd_i.scan_rd;
  assign mem_raddr = cmd_i.centre_rd ? {prslot_q, pc_q} : {wslot_q, wc_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= pix_q;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign violate = pend_q && !self_q &&
                   (early_q ? (rdata_q >= centre_q) : (rdata_q > centre_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(1024);
      height_q <= HeightW'(1024);
      rad_q    <= RadW'(1);
      thresh_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
          CfgRadius: rad_q    <= cfg_data_i[RadW-1:0];
          CfgThresh: thresh_q <= cfg_data_i[PixW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.prep) begin
        row_q  <= row_n;
        col_q  <= col_n;
        slot_q <= slot_n;
      end
      pend_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= in_item_i.pixel_value;
      fs_q  <= in_item_i.frame_start;
    end
    if (cmd_i.prep) begin
      pr_q     <= rlo;
      rhi_q    <= rhi;
      pc_q     <= clo;
      clo_q    <= clo;
      chi_q    <= chi;
      prslot_q <= rlo_slot;
    end
    if (cmd_i.advance) begin
      if (pc_q == chi_q) begin
        pc_q     <= clo_q;
        pr_q     <= pr_q + RowW'(1);
        prslot_q <= slot_inc(prslot_q);
      end else begin
        pc_q <= pc_q + ColW'(1);
      end
    end
    if (cmd_i.scan_init) begin
      centre_q <= rdata_q;
      peak_q   <= rdata_q > thresh_q;
      wr_q     <= wrlo;
      wrhi_q   <= wrhi;
      wc_q     <= wclo;
      wclo_q   <= wclo;
      wchi_q   <= wchi;
      wslot_q  <= slot_sub(prslot_q, RadW'(pr_q - wrlo));
    end
    if (cmd_i.scan_rd) begin
      self_q  <= (wr_q == pr_q) && (wc_q == pc_q);
      early_q <= (wr_q < pr_q) || ((wr_q == pr_q) && (wc_q < pc_q));
      if (wc_q == wchi_q) begin
        wc_q    <= wclo_q;
        wr_q    <= wr_q + RowW'(1);
        wslot_q <= slot_inc(wslot_q);
      end else begin
        wc_q <= wc_q + ColW'(1);
      end
    end
    if (violate) peak_q <= 1'b0;
  end

  assign sts_o.has_run   = rows_ok & cols_ok;
  assign sts_o.scan_last = (wr_q == wrhi_q) && (wc_q == wchi_q);
  assign sts_o.run_last  = (pr_q == rhi_q) && (pc_q == chi_q);

  assign out_item_o.out_row     = pr_q;
  assign out_item_o.out_col     = pc_q;
  assign out_item_o.is_peak     = peak_q;
  assign out_item_o.last_of_run = sts_o.run_last;

endmodule

/* hw/rtl/non_max_suppression_2d_core.sv */
// ----------------------------------------------------------------------------
// non_max_suppression_2d_core
// Streaming 2-D non-maximum suppression over a raster pixel stream.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o   | pix_in_t
//   out     | output    | out_valid_o/out_stall_i | dec_out_t
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An item is captured and stored; each decision it releases then scans the
// clipped window of n pixels (up to 169) through the single read port of the
// line store. No new item is taken until the last decision is handed out.
// Reset clears counters and loads register defaults; the line store is not
// cleared. A stalled decision holds on the output until taken.
// ----------------------------------------------------------------------------
module non_max_suppression_2d_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nms2d_pkg::pix_in_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nms2d_pkg::dec_out_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [nms2d_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nms2d_pkg::CfgW-1:0]    cfg_data_i
);
  import nms2d_pkg::*;

  nms2d_cmd_t cmd;
  nms2d_sts_t sts;

  nms2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nms2d_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
